// ===== rtl/core/qos_pkg.sv =====
// Package for the quadratic outline segmenter: widths, segment kinds and the
// segment and queue entry types used by the front, queue and back.
// Depends on nothing.
package qos_pkg;

   localparam int COORD_BITS    = 16;
   localparam int OUT_BITS      = COORD_BITS + 1;
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((6 * OUT_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_LINE  = 2'd0,
      KIND_CURVE = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OUT_BITS-1:0]   half_type;

   typedef struct packed {
      kind_type kind;
      half_type p0_x;
      half_type p0_y;
      half_type p1_x;
      half_type p1_y;
      half_type p2_x;
      half_type p2_y;
      logic     closes;
   } seg_type;

   // One queue entry: the results caused by one item, one or two of them.
   typedef struct packed {
      logic    second_valid;
      seg_type first;
      seg_type second;
   } job_type;

   // Font units to half units.
   function automatic half_type to_half(input coord_type v);
      return {v, 1'b0};
   endfunction

   function automatic seg_type make_seg(input kind_type kind,
                                        input half_type ax, input half_type ay,
                                        input half_type bx, input half_type by,
                                        input half_type cx, input half_type cy,
                                        input logic closes);
      seg_type s;
      s.kind   = kind;
      s.p0_x   = ax;
      s.p0_y   = ay;
      s.p1_x   = bx;
      s.p1_y   = by;
      s.p2_x   = cx;
      s.p2_y   = cy;
      s.closes = closes;
      return s;
   endfunction

endpackage

// ===== rtl/core/qos_front.sv =====
// Front part of the outline segmenter: accepts contour points, tracks the
// contour state and builds the segments, up to two, that each point causes.
// Depends on qos_pkg.
module qos_front
   import qos_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     push_valid,
   output job_type                  push_job,
   input  logic                     push_ready
);

   logic      open_ff, open_in;
   logic      skip_ff, skip_in;
   logic      pend_ff, pend_in;
   coord_type first_x_ff, first_x_in, first_y_ff, first_y_in;
   half_type  start_x_ff, start_x_in, start_y_ff, start_y_in;
   coord_type ctrl_x_ff, ctrl_x_in, ctrl_y_ff, ctrl_y_in;

   coord_type px, py;
   half_type  mid_x, mid_y;
   logic      accept;
   logic      item_valid;
   seg_type   item_seg;
   seg_type   close_seg;

   assign px = req_tdata[COORD_BITS-1:0];
   assign py = req_tdata[2*COORD_BITS-1:COORD_BITS];

   // Implied on-curve midpoint, exact in half units.
   assign mid_x = half_type'(ctrl_x_ff) + half_type'(px);
   assign mid_y = half_type'(ctrl_y_ff) + half_type'(py);

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      open_in    = open_ff;
      skip_in    = skip_ff;
      pend_in    = pend_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      ctrl_x_in  = ctrl_x_ff;
      ctrl_y_in  = ctrl_y_ff;
      item_valid = 1'b0;
      item_seg   = make_seg(KIND_LINE, '0, '0, '0, '0, '0, '0, 1'b0);
      close_seg  = item_seg;
      push_valid = 1'b0;
      push_job   = '0;

      if (skip_ff) begin
         if (req_tlast) begin
            skip_in = 1'b0;
         end
      end else if (!open_ff) begin
         if (!req_tuser) begin
            push_valid     = 1'b1;
            push_job.first = make_seg(KIND_BAD, to_half(px), to_half(py),
                                      '0, '0, '0, '0, 1'b0);
            skip_in = !req_tlast;
         end else begin
            first_x_in = px;
            first_y_in = py;
            start_x_in = to_half(px);
            start_y_in = to_half(py);
            pend_in    = 1'b0;
            if (req_tlast) begin
               push_valid     = 1'b1;
               push_job.first = make_seg(KIND_LINE, to_half(px), to_half(py),
                                         to_half(px), to_half(py), '0, '0, 1'b1);
            end else begin
               open_in = 1'b1;
            end
         end
      end else begin
         if (req_tuser) begin
            item_valid = 1'b1;
            if (pend_ff) begin
               item_seg = make_seg(KIND_CURVE, start_x_ff, start_y_ff,
                                   to_half(ctrl_x_ff), to_half(ctrl_y_ff),
                                   to_half(px), to_half(py), 1'b0);
            end else begin
               item_seg = make_seg(KIND_LINE, start_x_ff, start_y_ff,
                                   to_half(px), to_half(py), '0, '0, 1'b0);
            end
            start_x_in = to_half(px);
            start_y_in = to_half(py);
            pend_in    = 1'b0;
         end else begin
            item_valid = pend_ff;
            item_seg   = make_seg(KIND_CURVE, start_x_ff, start_y_ff,
                                  to_half(ctrl_x_ff), to_half(ctrl_y_ff),
                                  mid_x, mid_y, 1'b0);
            if (pend_ff) begin
               start_x_in = mid_x;
               start_y_in = mid_y;
            end
            ctrl_x_in = px;
            ctrl_y_in = py;
            pend_in   = 1'b1;
         end

         // The closing segment starts where the segment above leaves off.
         if (pend_in) begin
            close_seg = make_seg(KIND_CURVE, start_x_in, start_y_in,
                                 to_half(ctrl_x_in), to_half(ctrl_y_in),
                                 to_half(first_x_ff), to_half(first_y_ff), 1'b1);
         end else begin
            close_seg = make_seg(KIND_LINE, start_x_in, start_y_in,
                                 to_half(first_x_ff), to_half(first_y_ff),
                                 '0, '0, 1'b1);
         end

         if (req_tlast) begin
            open_in    = 1'b0;
            pend_in    = 1'b0;
            push_valid = 1'b1;
            if (item_valid) begin
               push_job.first        = item_seg;
               push_job.second       = close_seg;
               push_job.second_valid = 1'b1;
            end else begin
               push_job.first = close_seg;
            end
         end else if (item_valid) begin
            push_valid     = 1'b1;
            push_job.first = item_seg;
         end
      end

      push_valid = push_valid && req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         skip_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else if (accept) begin
         open_ff <= open_in;
         skip_ff <= skip_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         ctrl_x_ff  <= ctrl_x_in;
         ctrl_y_ff  <= ctrl_y_in;
      end
   end

endmodule

// ===== rtl/core/qos_queue.sv =====
// Short first-in first-out queue of segment jobs between the front and back
// parts of the outline segmenter. Depends on qos_pkg.
module qos_queue
   import qos_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop_ready
);

   job_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]    count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/qos_back.sv =====
// Back part of the outline segmenter: takes jobs from the queue and hands
// their segments out one at a time through an output register.
// Depends on qos_pkg.
module qos_back
   import qos_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  job_type                  pop_job,
   output logic                     pop_ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   logic    valid_ff, valid_in;
   logic    half_ff, half_in;
   seg_type seg_ff, seg_in;
   logic    load;

   // The output register may be refilled when empty or being taken.
   assign load = pop_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      half_in   = half_ff;
      seg_in    = seg_ff;
      pop_ready = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         seg_in   = half_ff ? pop_job.second : pop_job.first;
         if (pop_job.second_valid && !half_ff) begin
            half_in = 1'b1;
         end else begin
            half_in   = 1'b0;
            pop_ready = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({seg_ff.p2_y, seg_ff.p2_x, seg_ff.p1_y,
                                       seg_ff.p1_x, seg_ff.p0_y, seg_ff.p0_x});
   assign rsp_tuser  = seg_ff.kind;
   assign rsp_tlast  = seg_ff.closes;

endmodule

// ===== rtl/core/quadratic_outline_segmenter_core.sv =====
// The first segment of a point passes through the job queue and the output register
// before it is offered on rsp. Throughput: one point per cycle while the queue has room;
// the output register passes one segment per cycle while rsp_tready is high.
// A four-entry job queue lets points keep arriving while segments are stalled.
// Reset is synchronous and active high; it empties the queue and the output
// register and returns the contour tracking to awaiting a first point.
module quadratic_outline_segmenter_core
   import qos_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // point_x, point_y
   input  logic                     req_tuser,   // on_outline
   input  logic                     req_tlast,   // last_in_contour
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
   output logic [1:0]               rsp_tuser,   // segment_kind
   output logic                     rsp_tlast    // closes_contour
);

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   qos_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   qos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   qos_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/qos_checker.sv =====
// Port-level checks for the outline segmenter, bound to the top level.
// Depends on qos_pkg and quadratic_outline_segmenter_core.
module qos_checker
   import qos_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic                     req_tuser,
   input logic                     req_tlast,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [1:0]               rsp_tuser,
   input logic                     rsp_tlast
);

   // Nothing leaves the block in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A malformed contour report never closes and carries only its start point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BAD |->
         !rsp_tlast && rsp_tdata[RSP_DATA_BITS-1:2*OUT_BITS] == '0)
      else $error("malformed report with segment data");

   // A line carries no curve end point p2.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_LINE |->
         rsp_tdata[RSP_DATA_BITS-1:4*OUT_BITS] == '0)
      else $error("line with non-zero curve end point");

   // Only the three defined kinds are ever shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_LINE || rsp_tuser == KIND_CURVE
                     || rsp_tuser == KIND_BAD)
      else $error("undefined segment kind");

endmodule

bind quadratic_outline_segmenter_core qos_checker u_checker (.*);
